/* rtl/rca_pkg.sv */
package rca_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int NEED_W      = 5;
  localparam int TIME_W      = 16;
  localparam int FREE_W      = 18;
  localparam int ID_W        = 8;
  localparam int UNIT_W      = 4;

  typedef struct packed {
    logic [UNIT_W-1:0] unit_index;
    logic              has_predecessor;
    logic [ID_W-1:0]   pred_train;
    logic [ID_W-1:0]   pred_activity;
    logic              no_chain;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [FREE_W-1:0] free_time;
    logic [ID_W-1:0]   train;
    logic [ID_W-1:0]   activity;
  } tail_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EVAL = 3'b100
  } state_t;

endpackage

/* rtl/rca_ram.sv */
module rca_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/rca_out_stage.sv */
module rca_out_stage
  import rca_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load_en,
  input  result_t load_data,
  input  logic    take,
  output logic    room,
  output logic    valid,
  output result_t data
);

  logic    valid_r, valid_nxt;
  result_t data_r, data_nxt;

  // a new item may be loaded in the cycle the waiting one leaves
  assign room  = !valid_r || take;
  assign valid = valid_r;
  assign data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (take) begin
      valid_nxt = 1'b0;
    end
    if (load_en) begin
      valid_nxt = 1'b1;
      data_nxt  = load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

endmodule

/* rtl/resource_chain_assigner.sv */
// channel   direction  handshake              payload
// in_       input      in_valid / in_ready    activity, resource, demand, times
// out_      output     out_valid / out_ready  chain, predecessor, error, last
//
// an item is taken in the idle state; its units are then placed one after another.
// chains of a resource fill from unit 0 upward, so a per-resource fill count marks used
// chains and one scan pointer serves the whole item. a used chain takes a tail memory
// read in the scan state, then a compare in the eval state, passed or taken; an
// empty-chain placement or the no-chain result is made in the scan state alone.
// a full output register stalls the scan.
// reset empties all chains at once (fill counts cleared); no memory sweep.
module resource_chain_assigner
  import rca_pkg::*;
#(
  parameter int NUM_RESOURCES = 8,
  parameter int MAX_UNITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_clear_chains,
  input  logic [2:0]  in_resource_index,
  input  logic [4:0]  in_units_available,
  input  logic [7:0]  in_train_index,
  input  logic [7:0]  in_activity_index,
  input  logic [15:0] in_start_time,
  input  logic [15:0] in_duration,
  input  logic [15:0] in_slack,
  input  logic [4:0]  in_units_needed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_unit_index,
  output logic        out_has_predecessor,
  output logic [7:0]  out_pred_train,
  output logic [7:0]  out_pred_activity,
  output logic        out_no_chain,
  output logic        out_last
);

  localparam int NUM_CHAINS = NUM_RESOURCES * MAX_UNITS;
  localparam int AW  = (NUM_CHAINS > 1) ? $clog2(NUM_CHAINS) : 1;
  localparam int RW  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int CW  = $clog2(MAX_UNITS + 1);
  localparam int AWX = AW + CW;
  localparam int TW  = $bits(tail_t);

  state_t             state_r, state_nxt;
  logic [RW-1:0]      res_r, res_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic [CW-1:0]      cap_r, cap_nxt;
  logic [NEED_W-1:0]  need_r, need_nxt;
  logic [NEED_W-1:0]  m_r, m_nxt;
  logic [CW-1:0]      u_r, u_nxt;
  logic [ID_W-1:0]    tr_r, tr_nxt;
  logic [ID_W-1:0]    act_r, act_nxt;
  logic [TIME_W-1:0]  st_r, st_nxt;
  logic [FREE_W-1:0]  free_r, free_nxt;
  logic               stay_r, stay_nxt;
  logic [CW-1:0]      fill_r   [NUM_RESOURCES];
  logic [CW-1:0]      fill_nxt [NUM_RESOURCES];

  logic [RW+2:0]      res_wide;
  logic [CW+3:0]      u_wide;
  logic [AWX-1:0]     addr_full;
  logic [AW-1:0]      addr;
  logic [CW-1:0]      cur_fill;
  logic               accept;
  logic               last_unit;

  logic               ram_we, ram_re;
  tail_t              ram_wdata, ram_rdata;

  logic               os_room, os_load;
  result_t            os_din, os_dout;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign res_wide  = {{RW{1'b0}}, in_resource_index};
  assign u_wide    = {4'b0000, u_r};
  assign addr_full = AWX'(res_r) * AWX'(MAX_UNITS) + AWX'(u_r);
  assign addr      = addr_full[AW-1:0];
  assign cur_fill  = fill_r[res_r];
  assign last_unit = (m_r + NEED_W'(1)) == need_r;

  assign ram_wdata = '{free_time: free_r, train: tr_r, activity: act_r};

  always_comb begin
    state_nxt  = state_r;
    res_nxt    = res_r;
    res_ok_nxt = res_ok_r;
    cap_nxt    = cap_r;
    need_nxt   = need_r;
    m_nxt      = m_r;
    u_nxt      = u_r;
    tr_nxt     = tr_r;
    act_nxt    = act_r;
    st_nxt     = st_r;
    free_nxt   = free_r;
    stay_nxt   = stay_r;
    fill_nxt   = fill_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    os_load    = 1'b0;
    os_din     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt    = res_wide[RW-1:0];
          res_ok_nxt = int'(in_resource_index) < NUM_RESOURCES;
          cap_nxt    = (int'(in_units_available) > MAX_UNITS) ? CW'(MAX_UNITS)
                                                              : CW'(in_units_available);
          need_nxt   = (int'(in_units_needed) > MAX_RESULTS) ? NEED_W'(MAX_RESULTS)
                                                             : in_units_needed;
          m_nxt      = '0;
          u_nxt      = '0;
          tr_nxt     = in_train_index;
          act_nxt    = in_activity_index;
          st_nxt     = in_start_time;
          free_nxt   = FREE_W'(in_start_time) + FREE_W'(in_duration) + FREE_W'(in_slack);
          // zero duration and slack: the tail stays free at its own start
          stay_nxt   = (in_duration == '0) && (in_slack == '0);
          if (in_clear_chains) begin
            for (int i = 0; i < NUM_RESOURCES; i++) begin
              fill_nxt[i] = '0;
            end
          end
          if (in_units_needed != '0) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!res_ok_r || (u_r >= cap_r)) begin
          os_din.no_chain = 1'b1;
          os_din.last     = 1'b1;
          if (os_room) begin
            os_load   = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (u_r >= cur_fill) begin
          // empty chain, always fits
          os_din.unit_index = u_wide[3:0];
          os_din.last       = last_unit;
          if (os_room) begin
            os_load         = 1'b1;
            ram_we          = 1'b1;
            fill_nxt[res_r] = u_r + CW'(1);
            m_nxt           = m_r + NEED_W'(1);
            u_nxt           = stay_r ? u_r : u_r + CW'(1);
            if (last_unit) begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          ram_re    = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (FREE_W'(st_r) >= ram_rdata.free_time) begin
          os_din.unit_index      = u_wide[3:0];
          os_din.has_predecessor = 1'b1;
          os_din.pred_train      = ram_rdata.train;
          os_din.pred_activity   = ram_rdata.activity;
          os_din.last            = last_unit;
          if (os_room) begin
            os_load   = 1'b1;
            ram_we    = 1'b1;
            m_nxt     = m_r + NEED_W'(1);
            u_nxt     = stay_r ? u_r : u_r + CW'(1);
            state_nxt = last_unit ? ST_IDLE : ST_SCAN;
          end
        end else begin
          u_nxt     = u_r + CW'(1);
          state_nxt = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < NUM_RESOURCES; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
    res_r    <= res_nxt;
    res_ok_r <= res_ok_nxt;
    cap_r    <= cap_nxt;
    need_r   <= need_nxt;
    m_r      <= m_nxt;
    u_r      <= u_nxt;
    tr_r     <= tr_nxt;
    act_r    <= act_nxt;
    st_r     <= st_nxt;
    free_r   <= free_nxt;
    stay_r   <= stay_nxt;
  end

  rca_ram #(
    .WIDTH (TW),
    .DEPTH (NUM_CHAINS),
    .AW    (AW)
  ) u_tail_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  rca_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (os_load),
    .load_data (os_din),
    .take      (out_ready),
    .room      (os_room),
    .valid     (out_valid),
    .data      (os_dout)
  );

  assign out_unit_index      = os_dout.unit_index;
  assign out_has_predecessor = os_dout.has_predecessor;
  assign out_pred_train      = os_dout.pred_train;
  assign out_pred_activity   = os_dout.pred_activity;
  assign out_no_chain        = os_dout.no_chain;
  assign out_last            = os_dout.last;

endmodule

/* verif/resource_chain_assigner_tb.sv */
module resource_chain_assigner_tb;
  import rca_pkg::*;

  localparam int RES_COUNT     = 8;
  localparam int UNITS_PER_RES = 16;
  localparam int CHAIN_COUNT   = RES_COUNT * UNITS_PER_RES;
  localparam int DEMAND_CAP    = 16;

  typedef struct {
    logic        clr;
    logic [2:0]  res;
    logic [4:0]  cap;
    logic [7:0]  job;
    logic [7:0]  act;
    logic [15:0] st;
    logic [15:0] dur;
    logic [15:0] slk;
    logic [4:0]  need;
    bit          drain;
  } activity_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_clear_chains = 1'b0;
  logic [2:0]  in_resource_index = '0;
  logic [4:0]  in_units_available = '0;
  logic [7:0]  in_train_index = '0;
  logic [7:0]  in_activity_index = '0;
  logic [15:0] in_start_time = '0;
  logic [15:0] in_duration = '0;
  logic [15:0] in_slack = '0;
  logic [4:0]  in_units_needed = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_unit_index;
  logic        out_has_predecessor;
  logic [7:0]  out_pred_train;
  logic [7:0]  out_pred_activity;
  logic        out_no_chain;
  logic        out_last;

  resource_chain_assigner i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_clear_chains     (in_clear_chains),
    .in_resource_index   (in_resource_index),
    .in_units_available  (in_units_available),
    .in_train_index      (in_train_index),
    .in_activity_index   (in_activity_index),
    .in_start_time       (in_start_time),
    .in_duration         (in_duration),
    .in_slack            (in_slack),
    .in_units_needed     (in_units_needed),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_unit_index      (out_unit_index),
    .out_has_predecessor (out_has_predecessor),
    .out_pred_train      (out_pred_train),
    .out_pred_activity   (out_pred_activity),
    .out_no_chain        (out_no_chain),
    .out_last            (out_last)
  );

  // chain state as the block should hold it
  logic        chain_busy [CHAIN_COUNT];
  logic [17:0] tail_free  [CHAIN_COUNT];
  logic [7:0]  tail_job   [CHAIN_COUNT];
  logic [7:0]  tail_act   [CHAIN_COUNT];

  activity_t activity_queue[$];
  result_t   expected_placements[$];
  activity_t cur_activity;
  result_t   want;

  bit in_busy;
  bit in_taken;
  bit out_taken;
  int in_gap;
  int out_wait;
  int activities_sent;
  int results_seen;
  int placed_total;
  int reuse_total;
  int nochain_total;
  int mismatches;

  // idle-free stretch every 64 activities
  function automatic int draw_wait();
    if ((activities_sent % 64) < 12) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic place_activity(input activity_t a);
    int cap_n;
    int need_n;
    int pick;
    int idx;
    bit found;
    logic [17:0] free_at;
    result_t r;
    cap_n   = (a.cap > UNITS_PER_RES) ? UNITS_PER_RES : int'(a.cap);
    need_n  = (a.need > DEMAND_CAP) ? DEMAND_CAP : int'(a.need);
    free_at = 18'(a.st) + 18'(a.dur) + 18'(a.slk);
    if (a.clr) begin
      foreach (chain_busy[i]) chain_busy[i] = 1'b0;
    end
    for (int m = 0; m < need_n; m++) begin
      found = 1'b0;
      pick  = 0;
      if (a.res < RES_COUNT) begin
        for (int u = 0; u < cap_n; u++) begin
          idx = a.res * UNITS_PER_RES + u;
          if (!found && (!chain_busy[idx] || {2'b00, a.st} >= tail_free[idx])) begin
            found = 1'b1;
            pick  = u;
          end
        end
      end
      r = '0;
      if (!found) begin
        r.no_chain = 1'b1;
        r.last     = 1'b1;
        expected_placements = {expected_placements, r};
        nochain_total++;
        return;
      end
      idx          = a.res * UNITS_PER_RES + pick;
      r.unit_index = pick[3:0];
      r.last       = (m + 1 == need_n);
      if (chain_busy[idx]) begin
        r.has_predecessor = 1'b1;
        r.pred_train      = tail_job[idx];
        r.pred_activity   = tail_act[idx];
        reuse_total++;
      end
      expected_placements = {expected_placements, r};
      placed_total++;
      chain_busy[idx] = 1'b1;
      tail_free[idx]  = free_at;
      tail_job[idx]   = a.job;
      tail_act[idx]   = a.act;
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  task automatic add_activity(input bit clr, input int res, input int cap, input int job,
                              input int act, input int st, input int dur, input int slk,
                              input int need, input bit drain);
    activity_t a;
    a.clr   = clr;
    a.res   = res[2:0];
    a.cap   = cap[4:0];
    a.job   = job[7:0];
    a.act   = act[7:0];
    a.st    = st[15:0];
    a.dur   = dur[15:0];
    a.slk   = slk[15:0];
    a.need  = need[4:0];
    a.drain = drain;
    activity_queue = {activity_queue, a};
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // driver: one activity at a time, gap drawn after each accepted item
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_busy  = 1'b0;
        in_gap   = draw_wait();
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (activity_queue.size() > 0 &&
                     !(activity_queue[0].drain && expected_placements.size() != 0)) begin
          cur_activity       = activity_queue.pop_front();
          in_busy            = 1'b1;
          in_clear_chains    <= cur_activity.clr;
          in_resource_index  <= cur_activity.res;
          in_units_available <= cur_activity.cap;
          in_train_index     <= cur_activity.job;
          in_activity_index  <= cur_activity.act;
          in_start_time      <= cur_activity.st;
          in_duration        <= cur_activity.dur;
          in_slack           <= cur_activity.slk;
          in_units_needed    <= cur_activity.need;
        end
      end
      in_valid <= in_busy;
    end
  end

  // result side stall, drawn after each accepted result
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        out_taken = 1'b0;
        out_wait  = draw_wait();
      end
      if (out_wait > 0) begin
        out_ready <= 1'b0;
        out_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // prediction first so a result on the acceptance edge still finds its entry
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      place_activity(cur_activity);
      activities_sent++;
      in_taken = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      out_taken = 1'b1;
      results_seen++;
      if (expected_placements.size() == 0) begin
        $display("%0t: expected none got unit %0d pred %0d/%0d/%0d err %0d last %0d",
                 $time, out_unit_index, out_has_predecessor, out_pred_train,
                 out_pred_activity, out_no_chain, out_last);
        mismatches++;
      end else begin
        want = expected_placements.pop_front();
        check_field("unit_index", want.unit_index, out_unit_index);
        check_field("has_predecessor", want.has_predecessor, out_has_predecessor);
        check_field("pred_train", want.pred_train, out_pred_train);
        check_field("pred_activity", want.pred_activity, out_pred_activity);
        check_field("no_chain", want.no_chain, out_no_chain);
        check_field("last", want.last, out_last);
      end
    end
  end

  initial begin
    int total;
    int len;
    int t;
    int nres;
    int res;
    int cap;
    int need;
    int cap_of [RES_COUNT];
    foreach (chain_busy[i]) chain_busy[i] = 1'b0;

    // directed: extremes, saturation, errors, reuse of own tail, clear
    add_activity(1, 0, 16, 0, 0, 0, 0, 0, 1, 0);
    add_activity(0, 0, 1, 0, 0, 0, 0, 0, 1, 0);
    add_activity(0, 0, 16, 1, 1, 0, 0, 0, 0, 0);
    add_activity(0, 1, 31, 4, 4, 100, 50, 0, 31, 0);
    add_activity(0, 1, 16, 5, 5, 120, 0, 0, 1, 0);
    add_activity(0, 1, 16, 255, 255, 150, 1, 1, 2, 0);
    add_activity(0, 3, 0, 6, 6, 150, 0, 0, 1, 0);
    add_activity(0, 7, 2, 170, 85, 65535, 65535, 65535, 2, 0);
    add_activity(0, 7, 2, 85, 170, 65535, 0, 0, 1, 0);
    add_activity(0, 2, 2, 9, 9, 200, 10, 5, 3, 1);
    add_activity(1, 7, 2, 10, 10, 0, 0, 0, 1, 0);
    add_activity(0, 7, 17, 11, 11, 0, 65535, 0, 16, 0);
    add_activity(0, 5, 16, 12, 12, 300, 0, 65535, 17, 0);
    add_activity(0, 5, 16, 13, 13, 65535, 0, 0, 16, 1);
    add_activity(0, 6, 3, 14, 14, 400, 3, 2, 4, 0);
    add_activity(0, 6, 3, 15, 15, 405, 0, 0, 3, 0);

    // random schedules: sorted start times after a clear, some noise
    total = 0;
    while (total < 256) begin
      len  = $urandom_range(6, 24);
      t    = $urandom_range(0, 200);
      nres = $urandom_range(1, RES_COUNT);
      foreach (cap_of[r])
        cap_of[r] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 9) == 0) begin
          add_activity($urandom_range(0, 3) == 0, $urandom_range(0, 7), $urandom_range(0, 31),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 31), 0);
        end else begin
          res  = $urandom_range(0, nres - 1);
          cap  = cap_of[res];
          t    = t + $urandom_range(0, 6);
          need = ($urandom_range(0, 3) == 0) ? $urandom_range(0, (cap + 2 > 31) ? 31 : cap + 2)
                                            : $urandom_range(1, 2);
          add_activity(j == 0, res, cap, $urandom_range(0, 255), $urandom_range(0, 255), t,
                       $urandom_range(0, 30), $urandom_range(0, 8), need,
                       $urandom_range(0, 40) == 0);
        end
        total++;
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (activity_queue.size() > 0 || in_busy || expected_placements.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);

    $display("covered %0d activities, %0d results: %0d placements (%0d after a tail),",
             activities_sent, results_seen, placed_total, reuse_total);
    $display("%0d with no chain free", nochain_total);
    if (mismatches == 0 && expected_placements.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
rtl/rca_pkg.sv
rtl/rca_ram.sv
rtl/rca_out_stage.sv
rtl/resource_chain_assigner.sv
verif/resource_chain_assigner_tb.sv
